[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the sequencer top module. They compile to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

[design/fps_pkg.sv]
// ----------------------------------------------------------------------------
// Flight phase sequencer package
// Word types, register indexes, phase codes and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fps_pkg;

    // Samples in one launch averaging window.
    localparam int WINDOW_LEN = 10;
    localparam int WIN_CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W      = 32 + $clog2(WINDOW_LEN + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int STILL_W    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_ACCEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APOGEE_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_DEPLOY_ALT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_BAND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LANDED_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LANDED_SAMPLES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DROGUE_MIN_ALT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_MIN_ALT    = 3'd7;

    localparam logic [2:0] PH_STANDBY = 3'd0;
    localparam logic [2:0] PH_THRUST  = 3'd1;
    localparam logic [2:0] PH_COAST   = 3'd2;
    localparam logic [2:0] PH_APOGEE  = 3'd3;
    localparam logic [2:0] PH_MAIN    = 3'd4;
    localparam logic [2:0] PH_LANDED  = 3'd5;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] vel_down;
        logic signed [31:0] pos_down;
    } sample_t;

    typedef struct packed {
        logic [2:0] phase_now;
        logic       drogue_fire;
        logic       main_fire;
    } result_t;

    typedef struct packed {
        logic [30:0]        launch_accel;
        logic [30:0]        apogee_band;
        logic [30:0]        main_deploy_alt;
        logic [30:0]        still_band;
        logic [30:0]        landed_speed;
        logic [STILL_W-1:0] landed_samples;
        logic [30:0]        drogue_min_alt;
        logic [30:0]        main_min_alt;
    } cfg_t;

    // The launch average is kept as the undivided window sum; the compare
    // against the threshold is scaled by the window length instead.
    typedef struct packed {
        logic [2:0]              phase;
        logic signed [SUM_W-1:0] win_sum;
        logic [WIN_CNT_W-1:0]    win_count;
        logic                    win_active;
        logic signed [SUM_W-1:0] avg_sum;
        logic signed [31:0]      prev_vel;
        logic [STILL_W-1:0]      still_count;
    } state_t;

endpackage

[design/fps_step.sv]
// ----------------------------------------------------------------------------
// Flight phase step
// Next flight state and result word for one sample, from the current state
// and the threshold registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fps_step (
    input  fps_pkg::state_t  state,
    input  fps_pkg::cfg_t    cfg,
    input  fps_pkg::sample_t sample,
    output fps_pkg::state_t  state_next,
    output fps_pkg::result_t result
);

    logic [fps_pkg::SUM_W-1:0] launch_thr;
    logic                      avg_launch;
    logic signed [32:0]        acc_w;
    logic signed [32:0]        vel_w;
    logic signed [32:0]        pos_w;
    logic signed [33:0]        vel_diff;
    logic signed [33:0]        vel_diff_abs;
    logic                      is_still;
    logic [fps_pkg::STILL_W-1:0] still_inc;

    always_comb
    begin
        // trunc(sum / N) > L holds exactly when sum >= N * (L + 1), since L >= 0.
        launch_thr = (fps_pkg::SUM_W'(cfg.launch_accel) + fps_pkg::SUM_W'(1))
                     * fps_pkg::SUM_W'(fps_pkg::WINDOW_LEN);
        avg_launch = state.avg_sum >= $signed(launch_thr);

        acc_w = 33'(sample.accel_x);
        vel_w = 33'(sample.vel_down);
        pos_w = 33'(sample.pos_down);

        vel_diff     = 34'(sample.vel_down) - 34'(state.prev_vel);
        vel_diff_abs = (vel_diff < 0) ? -vel_diff : vel_diff;
        is_still     = (vel_diff_abs < $signed({3'b000, cfg.still_band}))
                       && (vel_w < $signed({2'b00, cfg.landed_speed}));
        still_inc    = (is_still && (state.still_count != '1))
                       ? state.still_count + fps_pkg::STILL_W'(1) : state.still_count;

        state_next = state;
        unique case (state.phase)
            fps_pkg::PH_STANDBY:
            begin
                if (avg_launch)
                begin
                    state_next.phase = fps_pkg::PH_THRUST;
                end
                else if (state.win_active)
                begin
                    if (state.win_count < fps_pkg::WIN_CNT_W'(fps_pkg::WINDOW_LEN))
                    begin
                        state_next.win_sum   = state.win_sum
                                               + fps_pkg::SUM_W'(sample.accel_x);
                        state_next.win_count = state.win_count + fps_pkg::WIN_CNT_W'(1);
                    end
                    else
                    begin
                        state_next.avg_sum    = state.win_sum;
                        state_next.win_count  = '0;
                        state_next.win_active = 1'b0;
                    end
                end
                else if (acc_w > $signed({2'b00, cfg.launch_accel}))
                begin
                    state_next.win_active = 1'b1;
                    state_next.win_sum    = fps_pkg::SUM_W'(sample.accel_x);
                    state_next.win_count  = fps_pkg::WIN_CNT_W'(1);
                end
            end
            fps_pkg::PH_THRUST:
            begin
                if (sample.vel_down > state.prev_vel)
                begin
                    state_next.phase = fps_pkg::PH_COAST;
                end
                state_next.prev_vel = sample.vel_down;
            end
            fps_pkg::PH_COAST:
            begin
                if ((vel_w > -$signed({2'b00, cfg.apogee_band}))
                    && (vel_w < $signed({2'b00, cfg.apogee_band})))
                begin
                    state_next.phase = fps_pkg::PH_APOGEE;
                end
            end
            fps_pkg::PH_APOGEE:
            begin
                if (pos_w > -$signed({2'b00, cfg.main_deploy_alt}))
                begin
                    state_next.phase       = fps_pkg::PH_MAIN;
                    state_next.prev_vel    = '0;
                    state_next.still_count = '0;
                end
            end
            fps_pkg::PH_MAIN:
            begin
                state_next.still_count = still_inc;
                if (still_inc >= cfg.landed_samples)
                begin
                    state_next.phase = fps_pkg::PH_LANDED;
                end
                state_next.prev_vel = sample.vel_down;
            end
            default:
            begin
                // Landed, and the unused codes, hold everything.
            end
        endcase

        result.phase_now   = state_next.phase;
        result.drogue_fire = (state_next.phase == fps_pkg::PH_APOGEE)
                             && (pos_w <= -$signed({2'b00, cfg.drogue_min_alt}));
        result.main_fire   = (state_next.phase == fps_pkg::PH_MAIN)
                             && (pos_w <= -$signed({2'b00, cfg.main_min_alt}));
    end

endmodule

[design/flight_phase_sequencer.sv]
// A sample word moves into the result register when that is empty or being read.
// Throughput: one word per cycle while result_ready is high; the sample register and
// the result register form a two-stage pipeline, and the flight state updates as a
// word leaves the sample register, so the sustained rate is one word per clock.
// Reset (rst_n low, asynchronous) returns to standby, clears the launch window,
// the averages and counters, and loads the default thresholds.
// ----------------------------------------------------------------------------
// Flight phase sequencer
// Steps through the six flight phases from navigation samples and raises the
// drogue and main chute fire flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flight_phase_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  fps_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_ready,
    output fps_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fps_pkg::cfg_t    cfg_reg;
    fps_pkg::state_t  state_reg;
    fps_pkg::state_t  state_next;
    fps_pkg::sample_t sample_reg;
    logic             sample_valid_reg;
    fps_pkg::result_t result_reg;
    fps_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             advance;

    assign advance      = sample_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !sample_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    fps_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.launch_accel    <= 31'd642908;
            cfg_reg.apogee_band     <= 31'd6554;
            cfg_reg.main_deploy_alt <= 31'd19660800;
            cfg_reg.still_band      <= 31'd6554;
            cfg_reg.landed_speed    <= 31'd131072;
            cfg_reg.landed_samples  <= 13'd5000;
            cfg_reg.drogue_min_alt  <= 31'd1966080;
            cfg_reg.main_min_alt    <= 31'd655360;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fps_pkg::REG_LAUNCH_ACCEL:    cfg_reg.launch_accel    <= cfg_data;
                fps_pkg::REG_APOGEE_BAND:     cfg_reg.apogee_band     <= cfg_data;
                fps_pkg::REG_MAIN_DEPLOY_ALT: cfg_reg.main_deploy_alt <= cfg_data;
                fps_pkg::REG_STILL_BAND:      cfg_reg.still_band      <= cfg_data;
                fps_pkg::REG_LANDED_SPEED:    cfg_reg.landed_speed    <= cfg_data;
                fps_pkg::REG_LANDED_SAMPLES:
                    cfg_reg.landed_samples <= cfg_data[fps_pkg::STILL_W-1:0];
                fps_pkg::REG_DROGUE_MIN_ALT:  cfg_reg.drogue_min_alt  <= cfg_data;
                fps_pkg::REG_MAIN_MIN_ALT:    cfg_reg.main_min_alt    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_ready)
            begin
                sample_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                state_reg        <= state_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            sample_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_CLK(a_phase_legal, clk, rst_n, state_reg.phase <= fps_pkg::PH_LANDED)
    `ASSERT_IMPL(a_phase_hold, clk, rst_n, !advance, ##1 $stable(state_reg.phase))
    `ASSERT_IMPL(a_phase_forward, clk, rst_n, advance,
                 ##1 (state_reg.phase >= $past(state_reg.phase)))
    `ASSERT_IMPL(a_drogue_phase, clk, rst_n, result_valid_reg && result_reg.drogue_fire,
                 result_reg.phase_now == fps_pkg::PH_APOGEE)
    `ASSERT_CLK(a_window_bound, clk, rst_n,
                state_reg.win_count <= fps_pkg::WIN_CNT_W'(fps_pkg::WINDOW_LEN))

endmodule

[verif/tb.sv]
// -----------------------------------------------------------------------------
// Flight phase sequencer testbench
// Flies one whole flight through the sequencer: standby with launch averaging
// windows, thrust, coast, apogee, main chute and landed. Each phase but landed gets a
// few hand-picked edge samples as well as random samples, with register writes
// between groups. An in-bench flight model predicts every result word, and a
// checker compares the words that come out against the predictions in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int STILL_TOP = (1 << fps_pkg::STILL_W) - 1;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    fps_pkg::sample_t               sample = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    fps_pkg::result_t               result;
    logic                           cfg_we = 1'b0;
    logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // 0: sender idles 34 of 100, receiver 69; 1: the other way round; 2: no idling.
    int               idle_mode = 0;
    int               words_sent = 0;
    int               mismatches = 0;
    fps_pkg::result_t pending_results[$];

    // Flight state as the block should hold it, and the register contents.
    logic [2:0] fl_phase = fps_pkg::PH_STANDBY;
    longint     launch_sum = 0;
    int         launch_count = 0;
    bit         launch_open = 1'b0;
    longint     launch_avg = 0;
    longint     last_vel = 0;
    int         still_run = 0;
    longint     thresh [8] = '{642908, 6554, 19660800, 6554, 131072, 5000, 1966080, 655360};

    flight_phase_sequencer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic fps_pkg::result_t advance_flight(fps_pkg::sample_t s);
        longint           acc;
        longint           vel;
        longint           pos;
        longint           diff;
        fps_pkg::result_t r;
        acc = longint'(s.accel_x);
        vel = longint'(s.vel_down);
        pos = longint'(s.pos_down);
        case (fl_phase)
            fps_pkg::PH_STANDBY:
            begin
                if (launch_avg > thresh[fps_pkg::REG_LAUNCH_ACCEL])
                    fl_phase = fps_pkg::PH_THRUST;
                else if (launch_open)
                begin
                    // The average is taken on the word after the window fills.
                    if (launch_count < fps_pkg::WINDOW_LEN)
                    begin
                        launch_sum += acc;
                        launch_count++;
                    end
                    else
                    begin
                        launch_avg = launch_sum / fps_pkg::WINDOW_LEN;
                        launch_count = 0;
                        launch_open = 1'b0;
                    end
                end
                else if (acc > thresh[fps_pkg::REG_LAUNCH_ACCEL])
                begin
                    launch_open = 1'b1;
                    launch_sum = acc;
                    launch_count = 1;
                end
            end
            fps_pkg::PH_THRUST:
            begin
                if (vel > last_vel)
                    fl_phase = fps_pkg::PH_COAST;
                last_vel = vel;
            end
            fps_pkg::PH_COAST:
            begin
                if (vel > -thresh[fps_pkg::REG_APOGEE_BAND]
                    && vel < thresh[fps_pkg::REG_APOGEE_BAND])
                    fl_phase = fps_pkg::PH_APOGEE;
            end
            fps_pkg::PH_APOGEE:
            begin
                if (pos > -thresh[fps_pkg::REG_MAIN_DEPLOY_ALT])
                begin
                    last_vel = 0;
                    still_run = 0;
                    fl_phase = fps_pkg::PH_MAIN;
                end
            end
            fps_pkg::PH_MAIN:
            begin
                diff = vel - last_vel;
                if (diff < 0)
                    diff = -diff;
                if (diff < thresh[fps_pkg::REG_STILL_BAND]
                    && vel < thresh[fps_pkg::REG_LANDED_SPEED]
                    && still_run < STILL_TOP)
                    still_run++;
                if (still_run >= thresh[fps_pkg::REG_LANDED_SAMPLES])
                    fl_phase = fps_pkg::PH_LANDED;
                last_vel = vel;
            end
            default: ;
        endcase
        r.phase_now   = fl_phase;
        r.drogue_fire = (fl_phase == fps_pkg::PH_APOGEE)
                        && (pos <= -thresh[fps_pkg::REG_DROGUE_MIN_ALT]);
        r.main_fire   = (fl_phase == fps_pkg::PH_MAIN)
                        && (pos <= -thresh[fps_pkg::REG_MAIN_MIN_ALT]);
        return r;
    endfunction

    function automatic fps_pkg::sample_t mk_sample(logic signed [31:0] acc,
                                                   logic signed [31:0] vel,
                                                   logic signed [31:0] pos);
        fps_pkg::sample_t s;
        s.accel_x  = acc;
        s.vel_down = vel;
        s.pos_down = pos;
        return s;
    endfunction

    function automatic logic signed [31:0] rnd_word();
        return $urandom;
    endfunction

    task automatic send_sample(input fps_pkg::sample_t s);
        int pct;
        pct = (idle_mode == 0) ? 34 : (idle_mode == 1) ? 69 : 0;
        // Each cycle the sender may sit idle with the chosen likelihood.
        while ($urandom_range(99) < pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_results.push_back(advance_flight(s));
        words_sent++;
        idle_mode = (words_sent < 330) ? 0 : (words_sent < 660) ? 1 : 2;
    endtask

    // Registers change only once every result word is back and the pipe is empty.
    task automatic write_reg(input logic [fps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fps_pkg::CFG_DATA_W-1:0] val);
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        thresh[idx] = (idx == fps_pkg::REG_LANDED_SAMPLES)
                      ? longint'(val[fps_pkg::STILL_W-1:0]) : longint'(val);
    endtask

    task automatic test_standby_quiet();
        // No sample can exceed the largest threshold, so no window opens.
        write_reg(fps_pkg::REG_LAUNCH_ACCEL, 31'h7FFF_FFFF);
        send_sample(mk_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_sample(mk_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_sample(mk_sample(0, 0, 0));
    endtask

    task automatic test_launch_average_rounding();
        longint lvl;
        write_reg(fps_pkg::REG_LAUNCH_ACCEL, 31'd642908);
        lvl = thresh[fps_pkg::REG_LAUNCH_ACCEL];
        // Ten times the threshold plus nine truncates back to the threshold,
        // which is not above it, so the block stays in standby.
        send_sample(mk_sample(32'(lvl + 9), rnd_word(), rnd_word()));
        repeat (fps_pkg::WINDOW_LEN - 1)
            send_sample(mk_sample(32'(lvl), rnd_word(), rnd_word()));
        repeat (2) send_sample(mk_sample(0, rnd_word(), rnd_word()));
    endtask

    task automatic test_standby_random();
        int     n;
        longint span;
        longint a;
        write_reg(fps_pkg::REG_LAUNCH_ACCEL, {2'b10, 29'($urandom)});
        span = 64'sh7FFF_FFFF - thresh[fps_pkg::REG_LAUNCH_ACCEL];
        for (n = 0; n < 240 && fl_phase == fps_pkg::PH_STANDBY; n++)
        begin
            if (launch_open)
                a = longint'(rnd_word());
            else if ($urandom_range(3) == 0)
                a = longint'($signed({1'b1, 31'($urandom)}));
            else
            begin
                a = longint'($urandom_range(32'(span - 1)));
                a = a + thresh[fps_pkg::REG_LAUNCH_ACCEL] + 1;
            end
            send_sample(mk_sample(32'(a), rnd_word(), rnd_word()));
        end
    endtask

    task automatic test_launch();
        int n;
        write_reg(fps_pkg::REG_LAUNCH_ACCEL, '0);
        for (n = 0; n < 40 && fl_phase == fps_pkg::PH_STANDBY; n++)
            send_sample(mk_sample({2'b01, 30'($urandom)}, rnd_word(), rnd_word()));
    endtask

    task automatic test_thrust();
        int     n;
        longint dn;
        send_sample(mk_sample(rnd_word(), 0, rnd_word()));
        send_sample(mk_sample(rnd_word(), -1, rnd_word()));
        for (n = 0; n < 130 && fl_phase == fps_pkg::PH_THRUST; n++)
        begin
            dn = longint'($urandom_range(1 << 20));
            send_sample(mk_sample(rnd_word(), 32'(last_vel - dn), rnd_word()));
        end
        // Hold the most negative velocity, then rise by one to reach burnout.
        repeat (2) send_sample(mk_sample(rnd_word(), 32'sh8000_0000, rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'sh8000_0001, rnd_word()));
    endtask

    task automatic test_coast();
        int     n;
        longint b;
        longint m;
        send_sample(mk_sample(rnd_word(), 32'(thresh[fps_pkg::REG_APOGEE_BAND]), rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'(-thresh[fps_pkg::REG_APOGEE_BAND]), rnd_word()));
        // An empty band can never hold the velocity.
        write_reg(fps_pkg::REG_APOGEE_BAND, '0);
        send_sample(mk_sample(rnd_word(), 0, rnd_word()));
        repeat (40) send_sample(mk_sample(rnd_word(), rnd_word(), rnd_word()));
        write_reg(fps_pkg::REG_APOGEE_BAND, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), 32'sh7FFF_FFFF, rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'sh8000_0000, rnd_word()));
        write_reg(fps_pkg::REG_APOGEE_BAND, 31'($urandom_range(1 << 24, 1)));
        b = thresh[fps_pkg::REG_APOGEE_BAND];
        for (n = 0; n < 100 && fl_phase == fps_pkg::PH_COAST; n++)
        begin
            if ($urandom_range(29) == 0)
                m = longint'($urandom_range(32'(b - 1)));
            else
            begin
                m = longint'($urandom_range(32'(b)));
                m = m + b;
            end
            if ($urandom_range(1))
                m = -m;
            send_sample(mk_sample(rnd_word(), 32'(m), rnd_word()));
        end
        while (fl_phase == fps_pkg::PH_COAST)
            send_sample(mk_sample(rnd_word(), 0, rnd_word()));
    endtask

    task automatic test_apogee();
        int     n;
        longint d;
        longint p;
        send_sample(mk_sample(rnd_word(), rnd_word(),
                              32'(-thresh[fps_pkg::REG_MAIN_DEPLOY_ALT])));
        write_reg(fps_pkg::REG_MAIN_DEPLOY_ALT, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), rnd_word(), 32'sh8000_0000));
        write_reg(fps_pkg::REG_DROGUE_MIN_ALT, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), rnd_word(), 32'sh8000_0001));
        write_reg(fps_pkg::REG_MAIN_DEPLOY_ALT, '0);
        write_reg(fps_pkg::REG_DROGUE_MIN_ALT, '0);
        send_sample(mk_sample(rnd_word(), rnd_word(), 0));
        // With the deploy height at zero, any position at or above launch holds apogee.
        write_reg(fps_pkg::REG_DROGUE_MIN_ALT, 31'($urandom));
        d = thresh[fps_pkg::REG_DROGUE_MIN_ALT];
        for (n = 0; n < 140 && fl_phase == fps_pkg::PH_APOGEE; n++)
        begin
            case ($urandom_range(9))
                0: p = -d;
                1: p = (d > 0) ? 1 - d : 0;
                2: p = 0;
                default: p = longint'($signed({1'b1, 31'($urandom)}));
            endcase
            send_sample(mk_sample(rnd_word(), rnd_word(), 32'(p)));
        end
        write_reg(fps_pkg::REG_MAIN_DEPLOY_ALT, 31'($urandom_range(32'h7FFF_FFFF, 1)));
        while (fl_phase == fps_pkg::PH_APOGEE)
            send_sample(mk_sample(rnd_word(), rnd_word(), 0));
    endtask

    task automatic test_main_chute();
        int     n;
        longint sb;
        longint d;
        longint v;
        // All ones masks down to the largest still count, so no landing yet.
        write_reg(fps_pkg::REG_LANDED_SAMPLES, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), 0, 32'(-thresh[fps_pkg::REG_MAIN_MIN_ALT])));
        send_sample(mk_sample(rnd_word(), 32'(thresh[fps_pkg::REG_STILL_BAND]),
                              32'(1 - thresh[fps_pkg::REG_MAIN_MIN_ALT])));
        send_sample(mk_sample(rnd_word(), 32'(thresh[fps_pkg::REG_STILL_BAND]), rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'(thresh[fps_pkg::REG_LANDED_SPEED]), rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'(thresh[fps_pkg::REG_LANDED_SPEED]), rnd_word()));
        write_reg(fps_pkg::REG_STILL_BAND, '0);
        send_sample(mk_sample(rnd_word(), 32'(last_vel), rnd_word()));
        write_reg(fps_pkg::REG_STILL_BAND, 31'h7FFF_FFFF);
        write_reg(fps_pkg::REG_LANDED_SPEED, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), 32'sh7FFF_FFFF, rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'sh8000_0000, rnd_word()));
        send_sample(mk_sample(rnd_word(), 32'sh8000_0000, rnd_word()));
        write_reg(fps_pkg::REG_LANDED_SPEED, '0);
        repeat (2) send_sample(mk_sample(rnd_word(), -1, rnd_word()));
        send_sample(mk_sample(rnd_word(), 0, rnd_word()));
        write_reg(fps_pkg::REG_MAIN_MIN_ALT, '0);
        send_sample(mk_sample(rnd_word(), rnd_word(), 0));
        send_sample(mk_sample(rnd_word(), rnd_word(), 1));
        write_reg(fps_pkg::REG_MAIN_MIN_ALT, 31'h7FFF_FFFF);
        send_sample(mk_sample(rnd_word(), rnd_word(), 32'sh8000_0001));
        send_sample(mk_sample(rnd_word(), rnd_word(), 32'sh8000_0002));

        write_reg(fps_pkg::REG_STILL_BAND, 31'($urandom_range(1 << 20, 1)));
        write_reg(fps_pkg::REG_LANDED_SPEED, 31'($urandom_range(1 << 22)));
        write_reg(fps_pkg::REG_MAIN_MIN_ALT, 31'($urandom));
        sb = thresh[fps_pkg::REG_STILL_BAND];
        for (n = 0; n < 180 && fl_phase == fps_pkg::PH_MAIN; n++)
        begin
            case ($urandom_range(9))
                0: v = longint'(rnd_word());
                1: v = 0;
                default:
                begin
                    // Small steps around the last velocity straddle the still band.
                    d = longint'($urandom_range(32'(4 * sb)));
                    v = last_vel + d - 2 * sb;
                    if (v > 64'sh7FFF_FFFF)
                        v = 64'sh7FFF_FFFF;
                    if (v < -64'sh8000_0000)
                        v = -64'sh8000_0000;
                end
            endcase
            send_sample(mk_sample(rnd_word(), 32'(v), rnd_word()));
        end
        // Only the low 13 bits are kept, so this sets a landing count of zero
        // and the next main chute word declares landing.
        write_reg(fps_pkg::REG_LANDED_SAMPLES, 31'h0000_2000);
        send_sample(mk_sample(rnd_word(), rnd_word(), rnd_word()));
    endtask

    task automatic test_landed();
        repeat (120) send_sample(mk_sample(rnd_word(), rnd_word(), rnd_word()));
    endtask

    always @(posedge clk)
    begin
        if (idle_mode == 0)
            result_ready <= ($urandom_range(99) >= 69);
        else if (idle_mode == 1)
            result_ready <= ($urandom_range(99) >= 34);
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        fps_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected: phase_now %0d", result.phase_now);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.phase_now !== want.phase_now)
                begin
                    $error("phase_now: expected %0d, got %0d", want.phase_now, result.phase_now);
                    mismatches++;
                end
                if (result.drogue_fire !== want.drogue_fire)
                begin
                    $error("drogue_fire: expected %0b, got %0b", want.drogue_fire,
                           result.drogue_fire);
                    mismatches++;
                end
                if (result.main_fire !== want.main_fire)
                begin
                    $error("main_fire: expected %0b, got %0b", want.main_fire, result.main_fire);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : run_flight
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_standby_quiet();
        test_launch_average_rounding();
        test_standby_random();
        test_launch();
        test_thrust();
        test_coast();
        test_apogee();
        test_main_chute();
        test_landed();
        sample_valid <= 1'b0;
        for (n = 0; n < 5000 && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** flight_phase_sequencer: PASSED **");
        else
            $display("** flight_phase_sequencer: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("** flight_phase_sequencer: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/fps_pkg.sv
design/fps_step.sv
design/flight_phase_sequencer.sv
verif/tb.sv
